// ===== sv/bspline_curve_subdivision_defines.svh =====
// Assertion macros shared by the subdivision block.
`ifndef BSPLINE_CURVE_SUBDIVISION_DEFINES_SVH
`define BSPLINE_CURVE_SUBDIVISION_DEFINES_SVH

// Same-cycle implication.
`define BCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bcs_pkg.sv =====
// Shared constants for the B-spline subdivision block.
`default_nettype none

package bcs_pkg;

   localparam int AXES         = 3;
   localparam int IO_BITS      = 32;
   localparam int LEVELS_BITS  = 3;
   localparam logic [LEVELS_BITS-1:0] LEVELS_RESET = 3'd1;

   localparam int PHASE_BITS = 2;
   localparam logic [PHASE_BITS-1:0] PH_VERTEX     = 2'd0;
   localparam logic [PHASE_BITS-1:0] PH_EDGE       = 2'd1;
   localparam logic [PHASE_BITS-1:0] PH_END_VERTEX = 2'd2;
   localparam logic [PHASE_BITS-1:0] PH_END_EDGE   = 2'd3;

endpackage

`default_nettype wire

// ===== sv/bspline_curve_subdivision.sv =====
// Top level of the streaming cubic B-spline curve subdivision block.
// Points of an open polyline enter one per request, tlast on the final point;
// up to MAX_LEVELS chained window stages refine them and results leave one
// per cycle while rsp_tready is high through a registered skid buffer, tlast
// on the final refined point. Each stage emits one result per cycle while its
// output is accepted; an interior point yields a vertex and an edge result at
// each level, a curve's first point only fills the window at stage 0, and its
// final point adds the end results of every level. A write to the levels
// register restarts the curve; values above MAX_LEVELS act as MAX_LEVELS and
// zero passes points through.
`default_nettype none

module bspline_curve_subdivision #(
   parameter int MAX_LEVELS = 4,
   parameter int COORD_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [95:0]                     req_tdata,   // px, py, pz
   input  wire logic                            req_tlast,   // final_point
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [95:0]                          rsp_tdata,   // qx, qy, qz
   output logic                                 rsp_tlast,   // curve_end
   input  wire logic                            csr_wr_en,
   input  wire logic [bcs_pkg::LEVELS_BITS-1:0] csr_wr_data  // levels
);

   localparam int Io = bcs_pkg::IO_BITS;
   localparam int OutBits = bcs_pkg::AXES * Io + 1;

   logic [bcs_pkg::LEVELS_BITS-1:0] levels_ff, levels_in, lv;

   logic [bcs_pkg::AXES-1:0][COORD_BITS-1:0] req_point;
   logic [bcs_pkg::AXES-1:0][Io-1:0]          req_word;
   logic [bcs_pkg::AXES-1:0][Io-1:0]          pass_word;

   logic [MAX_LEVELS-1:0]                            st_in_valid, st_in_ready;
   logic [MAX_LEVELS-1:0]                            st_out_valid, st_out_ready;
   logic [MAX_LEVELS-1:0]                            st_in_last, st_out_last;
   logic [MAX_LEVELS-1:0][bcs_pkg::AXES-1:0][COORD_BITS-1:0] st_in_point;
   logic [MAX_LEVELS-1:0][bcs_pkg::AXES-1:0][COORD_BITS-1:0] st_out_point;
   logic [MAX_LEVELS-1:0][bcs_pkg::AXES-1:0][Io-1:0]          st_out_word;

   logic               sk_in_valid, sk_in_ready;
   logic [OutBits-1:0] sk_in_data, sk_out_data;

   assign req_word  = req_tdata;
   assign levels_in = csr_wr_en ? csr_wr_data : levels_ff;
   assign lv = (levels_ff > bcs_pkg::LEVELS_BITS'(MAX_LEVELS))
               ? bcs_pkg::LEVELS_BITS'(MAX_LEVELS) : levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= bcs_pkg::LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   for (genvar c = 0; c < bcs_pkg::AXES; c++) begin : g_axis
      if (COORD_BITS > Io) begin : g_wide
         assign req_point[c] = {{(COORD_BITS-Io){req_word[c][Io-1]}}, req_word[c]};
         assign pass_word[c] = req_word[c];
         for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_out
            assign st_out_word[s][c] = st_out_point[s][c][Io-1:0];
         end
      end else if (COORD_BITS == Io) begin : g_same
         assign req_point[c] = req_word[c];
         assign pass_word[c] = req_word[c];
         for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_out
            assign st_out_word[s][c] = st_out_point[s][c];
         end
      end else begin : g_narrow
         assign req_point[c] = req_word[c][COORD_BITS-1:0];
         assign pass_word[c] =
            {{(Io-COORD_BITS){req_point[c][COORD_BITS-1]}}, req_point[c]};
         for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_out
            assign st_out_word[s][c] =
               {{(Io-COORD_BITS){st_out_point[s][c][COORD_BITS-1]}}, st_out_point[s][c]};
         end
      end
   end

   for (genvar s = 0; s < MAX_LEVELS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign st_in_valid[s] = req_tvalid && (lv != '0);
         assign st_in_point[s] = req_point;
         assign st_in_last[s]  = req_tlast;
      end else begin : g_next
         assign st_in_valid[s] = st_out_valid[s-1] && (bcs_pkg::LEVELS_BITS'(s) < lv);
         assign st_in_point[s] = st_out_point[s-1];
         assign st_in_last[s]  = st_out_last[s-1];
      end

      if (s == MAX_LEVELS - 1) begin : g_tail
         assign st_out_ready[s] = (bcs_pkg::LEVELS_BITS'(s + 1) == lv) && sk_in_ready;
      end else begin : g_body
         assign st_out_ready[s] = (bcs_pkg::LEVELS_BITS'(s + 1) < lv) ? st_in_ready[s+1]
                                : (bcs_pkg::LEVELS_BITS'(s + 1) == lv) && sk_in_ready;
      end

      bcs_stage #(
         .CoordBits(COORD_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .clear    (csr_wr_en),
         .in_valid (st_in_valid[s]),
         .in_ready (st_in_ready[s]),
         .in_point (st_in_point[s]),
         .in_last  (st_in_last[s]),
         .out_valid(st_out_valid[s]),
         .out_ready(st_out_ready[s]),
         .out_point(st_out_point[s]),
         .out_last (st_out_last[s])
      );
   end

   always_comb begin
      sk_in_valid = req_tvalid;
      sk_in_data  = {req_tlast, pass_word};
      req_tready  = sk_in_ready;
      if (lv != '0) begin
         req_tready = st_in_ready[0];
      end
      for (int s = 0; s < MAX_LEVELS; s++) begin
         if (lv == bcs_pkg::LEVELS_BITS'(s + 1)) begin
            sk_in_valid = st_out_valid[s];
            sk_in_data  = {st_out_last[s], st_out_word[s]};
         end
      end
   end

   bcs_skid #(
      .Width(OutBits)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sk_in_valid),
      .in_ready (sk_in_ready),
      .in_data  (sk_in_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (sk_out_data)
   );

   assign rsp_tdata = sk_out_data[OutBits-2:0];
   assign rsp_tlast = sk_out_data[OutBits-1];

endmodule

`default_nettype wire

// ===== sv/bcs_skid.sv =====
// Two-entry skid buffer that registers the result channel.
`default_nettype none

`include "bspline_curve_subdivision_defines.svh"

module bcs_skid #(
   parameter int Width = 97
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [Width-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [Width-1:0]      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             spare_valid_ff, spare_valid_in;
   logic [Width-1:0] main_data_ff, main_data_in;
   logic [Width-1:0] spare_data_ff, spare_data_in;

   assign in_ready  = !spare_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_data_in   = main_data_ff;
      spare_data_in  = spare_data_ff;
      if (!main_valid_ff || out_ready) begin
         if (spare_valid_ff) begin
            main_data_in   = spare_data_ff;
            main_valid_in  = 1'b1;
            spare_valid_in = 1'b0;
         end else begin
            main_data_in  = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid && in_ready) begin
         spare_data_in  = in_data;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff  <= main_data_in;
      spare_data_ff <= spare_data_in;
   end

   `BCS_ASSERT_IMP(spare_needs_main, clock, reset, spare_valid_ff, main_valid_ff, "skid spare filled with main empty")

endmodule

`default_nettype wire

// ===== sv/bcs_stage.sv =====
// One subdivision level: three-point window, up to four results per point.
`default_nettype none

`include "bspline_curve_subdivision_defines.svh"

module bcs_stage #(
   parameter int CoordBits = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     clear,
   input  wire logic                                     in_valid,
   output logic                                          in_ready,
   input  wire logic [bcs_pkg::AXES-1:0][CoordBits-1:0]  in_point,
   input  wire logic                                     in_last,
   output logic                                          out_valid,
   input  wire logic                                     out_ready,
   output logic [bcs_pkg::AXES-1:0][CoordBits-1:0]       out_point,
   output logic                                          out_last
);

   localparam int SumBits = CoordBits + 4;

   logic                                        busy_ff, busy_in;
   logic                                        seen_ff, seen_in;
   logic                                        fin_ff, fin_in;
   logic [bcs_pkg::PHASE_BITS-1:0]              phase_ff, phase_in;
   logic [bcs_pkg::AXES-1:0][CoordBits-1:0]     a_ff, a_in;
   logic [bcs_pkg::AXES-1:0][CoordBits-1:0]     b_ff, b_in;
   logic [bcs_pkg::AXES-1:0][CoordBits-1:0]     x_ff, x_in;

   logic [bcs_pkg::AXES-1:0][CoordBits-1:0]     vert, mid, endv, ap;
   logic [bcs_pkg::AXES-1:0][CoordBits-1:0]     base_a, base_b;
   logic                                        base_seen;
   logic                                        last_phase, done;

   always_comb begin
      logic signed [SumBits-1:0] sa, sb, sx, sap, sv, se, sev;
      sa = '0;
      sb = '0;
      sx = '0;
      sap = '0;
      sv = '0;
      se = '0;
      sev = '0;
      for (int c = 0; c < bcs_pkg::AXES; c++) begin
         ap[c]   = seen_ff ? b_ff[c] : x_ff[c];
         sa      = SumBits'($signed(a_ff[c]));
         sb      = SumBits'($signed(b_ff[c]));
         sx      = SumBits'($signed(x_ff[c]));
         sap     = SumBits'($signed(ap[c]));
         sv      = sa + (sb <<< 2) + (sb <<< 1) + sx;
         se      = sb + sx;
         sev     = sap + (sx <<< 3) - sx;
         vert[c] = sv[CoordBits+2:3];
         mid[c]  = se[CoordBits:1];
         endv[c] = sev[CoordBits+2:3];
      end
   end

   always_comb begin
      case (phase_ff)
         bcs_pkg::PH_VERTEX:     out_point = vert;
         bcs_pkg::PH_EDGE:       out_point = mid;
         bcs_pkg::PH_END_VERTEX: out_point = endv;
         default:                out_point = x_ff;
      endcase
      out_last  = phase_ff == bcs_pkg::PH_END_EDGE;
      out_valid = busy_ff;

      last_phase = (phase_ff == bcs_pkg::PH_END_EDGE) ||
                   (phase_ff == bcs_pkg::PH_EDGE && !fin_ff);
      done       = busy_ff && out_ready && last_phase;
      in_ready   = !busy_ff || done;

      // window as it stands once the held point has been fully emitted
      base_seen = busy_ff ? !fin_ff : seen_ff;
      base_a    = busy_ff ? ap : a_ff;
      base_b    = busy_ff ? x_ff : b_ff;

      busy_in  = busy_ff;
      seen_in  = seen_ff;
      fin_in   = fin_ff;
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;

      if (in_valid && in_ready) begin
         if (base_seen || in_last) begin
            busy_in  = 1'b1;
            seen_in  = base_seen;
            a_in     = base_a;
            b_in     = base_b;
            x_in     = in_point;
            fin_in   = in_last;
            phase_in = base_seen ? bcs_pkg::PH_VERTEX : bcs_pkg::PH_END_VERTEX;
         end else begin
            busy_in = 1'b0;
            seen_in = 1'b1;
            a_in    = in_point;
            b_in    = in_point;
         end
      end else if (done) begin
         busy_in = 1'b0;
         seen_in = base_seen;
         a_in    = base_a;
         b_in    = base_b;
      end else if (busy_ff && out_ready) begin
         phase_in = (phase_ff == bcs_pkg::PH_EDGE) ? bcs_pkg::PH_END_VERTEX
                                                    : phase_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         busy_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         phase_ff <= bcs_pkg::PH_VERTEX;
      end else begin
         busy_ff  <= busy_in;
         seen_ff  <= seen_in;
         fin_ff   <= fin_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      x_ff <= x_in;
   end

   `BCS_ASSERT_IMP(lone_point_ends_only, clock, reset, busy_ff && !seen_ff, phase_ff == bcs_pkg::PH_END_VERTEX || phase_ff == bcs_pkg::PH_END_EDGE, "point without neighbor emitting interior results")
   `BCS_ASSERT_IMP(inner_point_no_ends, clock, reset, busy_ff && !fin_ff, phase_ff == bcs_pkg::PH_VERTEX || phase_ff == bcs_pkg::PH_EDGE, "inner point emitting end results")
   `BCS_ASSERT_NXT(stall_holds_phase, clock, reset, busy_ff && !out_ready && !clear, busy_ff && $stable(phase_ff), "stage advanced while stalled")

endmodule

`default_nettype wire
